[design/base64_stream_decoder_unit_defines.svh]
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define B64D_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64D_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

[design/b64d_pkg.sv]
// shared types and constants for the base64 stream decoder
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int QDEPTH  = 6;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic       run_last;
        logic       byte_present;
        logic [7:0] byte_out;
    } t_result;

    localparam int RES_W = $bits(t_result);

    typedef struct packed {
        logic [1:0]  cnt;
        logic [17:0] sbuf;
        logic        halt;
        logic [1:0]  n;
        t_result [MAX_RES-1:0] res;
    } t_dec;

endpackage

[design/base64_stream_decoder_unit.sv]
// top level of the base64 stream decoder
//
// channel | dir | tdata            | tlast       | tuser
// s_axis  | in  | char_in[7:0]     | message_end | -
// m_axis  | out | byte_out[7:0]    | run_last    | byte_present
//
// one character per cycle is accepted; its results are known the same cycle
// and enter a six-entry result queue that sends one transaction per cycle
// input is taken while the queue has room for three results
// synchronous active-low reset clears the group state and empties the queue
// a stall on m_axis backs up the queue and then holds off s_axis
`timescale 1ns / 1ps

module base64_stream_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // char_in
    input  logic       i_s_axis_tlast,   // message_end
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // byte_out
    output logic       o_m_axis_tuser,   // byte_present
    output logic       o_m_axis_tlast    // run_last
);

    logic [1:0]        r_cnt;
    logic [17:0]       r_sbuf;
    logic              r_halt;
    b64d_pkg::t_dec    w_dec;
    b64d_pkg::t_result w_head;
    logic              w_accept;
    logic              w_space;

    assign o_s_axis_tready = w_space;
    assign w_accept        = i_s_axis_tvalid && w_space;

    b64d_decode u_decode (
        .i_char (i_s_axis_tdata),
        .i_last (i_s_axis_tlast),
        .i_cnt  (r_cnt),
        .i_sbuf (r_sbuf),
        .i_halt (r_halt),
        .o_dec  (w_dec)
    );

    b64d_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (w_accept ? w_dec.n : 2'd0),
        .i_push      (w_dec.res),
        .i_pop_ready (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_head      (w_head),
        .o_space     (w_space)
    );

    assign o_m_axis_tdata = w_head.byte_out;
    assign o_m_axis_tuser = w_head.byte_present;
    assign o_m_axis_tlast = w_head.run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_sbuf <= '0;
            r_halt <= 1'b0;
        end else if (w_accept) begin
            r_cnt  <= w_dec.cnt;
            r_sbuf <= w_dec.sbuf;
            r_halt <= w_dec.halt;
        end
    end

endmodule

[design/b64d_decode.sv]
// character decode, group packing, flush and end-of-message marking
`timescale 1ns / 1ps

module b64d_decode (
    input  logic [7:0]     i_char,
    input  logic           i_last,
    input  logic [1:0]     i_cnt,
    input  logic [17:0]    i_sbuf,
    input  logic           i_halt,
    output b64d_pkg::t_dec o_dec
);

    logic        sx_ok;
    logic [7:0]  sx_full;
    logic [5:0]  sx;
    logic [23:0] word;
    logic [1:0]  fcnt;
    logic [17:0] fbuf;

    always_comb begin
        sx_ok   = 1'b1;
        sx_full = 8'h00;
        if (i_char >= 8'h41 && i_char <= 8'h5a) begin
            sx_full = i_char - 8'h41;
        end else if (i_char >= 8'h61 && i_char <= 8'h7a) begin
            sx_full = i_char - 8'h47;
        end else if (i_char >= 8'h30 && i_char <= 8'h39) begin
            sx_full = i_char + 8'h04;
        end else if (i_char == 8'h2b) begin
            sx_full = 8'd62;
        end else if (i_char == 8'h2f) begin
            sx_full = 8'd63;
        end else begin
            sx_ok = 1'b0;
        end
        sx = sx_full[5:0];
    end

    always_comb begin
        o_dec      = '0;
        o_dec.cnt  = i_cnt;
        o_dec.sbuf = i_sbuf;
        o_dec.halt = i_halt;
        fcnt       = 2'd0;
        fbuf       = '0;
        word       = {i_sbuf, sx};

        if (!i_halt) begin
            if (sx_ok) begin
                if (i_cnt == 2'd3) begin
                    o_dec.res[0] = '{run_last: 1'b0, byte_present: 1'b1, byte_out: word[23:16]};
                    o_dec.res[1] = '{run_last: 1'b0, byte_present: 1'b1, byte_out: word[15:8]};
                    o_dec.res[2] = '{run_last: 1'b0, byte_present: 1'b1, byte_out: word[7:0]};
                    o_dec.n      = 2'd3;
                    o_dec.cnt    = 2'd0;
                    o_dec.sbuf   = '0;
                end else begin
                    o_dec.sbuf = {i_sbuf[11:0], sx};
                    o_dec.cnt  = i_cnt + 2'd1;
                end
            end else begin
                o_dec.halt = 1'b1;
                fcnt       = i_cnt;
                fbuf       = i_sbuf;
                o_dec.cnt  = 2'd0;
                o_dec.sbuf = '0;
            end
        end

        if (i_last && !o_dec.halt) begin
            fcnt = o_dec.cnt;
            fbuf = o_dec.sbuf;
        end

        // partial group of k sextets gives k-1 bytes
        case (fcnt)
            2'd2: begin
                o_dec.res[0] = '{run_last: 1'b0, byte_present: 1'b1, byte_out: fbuf[11:4]};
                o_dec.n      = 2'd1;
            end
            2'd3: begin
                o_dec.res[0] = '{run_last: 1'b0, byte_present: 1'b1, byte_out: fbuf[17:10]};
                o_dec.res[1] = '{run_last: 1'b0, byte_present: 1'b1, byte_out: fbuf[9:2]};
                o_dec.n      = 2'd2;
            end
            default: begin
            end
        endcase

        if (i_last) begin
            case (o_dec.n)
                2'd0: begin
                    o_dec.res[0] = '{run_last: 1'b1, byte_present: 1'b0, byte_out: 8'h00};
                    o_dec.n      = 2'd1;
                end
                2'd1: o_dec.res[0].run_last = 1'b1;
                2'd2: o_dec.res[1].run_last = 1'b1;
                2'd3: o_dec.res[2].run_last = 1'b1;
                default: begin
                end
            endcase
            o_dec.cnt  = 2'd0;
            o_dec.sbuf = '0;
            o_dec.halt = 1'b0;
        end
    end

endmodule

[design/b64d_outq.sv]
// result queue: takes up to three results per cycle, hands out one
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_defines.svh"

module b64d_outq (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic [1:0]                                  i_push_n,
    input  b64d_pkg::t_result [b64d_pkg::MAX_RES-1:0]   i_push,
    input  logic                                        i_pop_ready,
    output logic                                        o_valid,
    output b64d_pkg::t_result                           o_head,
    output logic                                        o_space
);

    localparam int W = b64d_pkg::RES_W;
    localparam int D = b64d_pkg::QDEPTH;

    logic [D*W-1:0]                r_q;
    logic [D*W-1:0]                n_q;
    logic [b64d_pkg::QCNT_W-1:0]   r_count;
    logic [b64d_pkg::QCNT_W-1:0]   n_count;
    logic [b64d_pkg::QCNT_W-1:0]   kept;
    logic [D*W-1:0]                shifted;
    logic                          w_pop;
    int                            j;

    assign o_valid = (r_count != '0);
    assign o_head  = r_q[W-1:0];
    assign o_space = (int'(r_count) <= D - b64d_pkg::MAX_RES);
    assign w_pop   = o_valid && i_pop_ready;

    always_comb begin
        kept    = r_count - b64d_pkg::QCNT_W'(w_pop);
        shifted = w_pop ? (r_q >> W) : r_q;
        n_q     = r_q;
        j       = 0;
        for (int i = 0; i < D; i++) begin
            j = i - int'(kept);
            if (i < int'(kept)) begin
                n_q[i*W +: W] = shifted[i*W +: W];
            end else if (j < int'(i_push_n)) begin
                n_q[i*W +: W] = i_push[j[1:0]];
            end
        end
        n_count = kept + b64d_pkg::QCNT_W'(i_push_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_q <= n_q;
    end

    `B64D_ASSERT(a_count_bound, i_clk, i_rst_n, int'(r_count) <= D, "queue count above depth")
    `B64D_ASSERT(a_no_overflow, i_clk, i_rst_n, (int'(r_count) + int'(i_push_n) - int'(w_pop)) <= D, "queue overflow")
    `B64D_ASSERT(a_pop_only, i_clk, i_rst_n, (w_pop && i_push_n == 2'd0) |=> (r_count == $past(r_count) - 1'b1), "pop did not drop count")
    `B64D_ASSERT(a_push_no_space, i_clk, i_rst_n, (i_push_n != 2'd0) |-> o_space, "push without space")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the base64 stream decoder: directed and random messages
module testbench;

    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int RANDOM_ITEMS    = 105;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_PAD   = 8'h3d;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} t_sink_mode;
    typedef enum int {TAIL_EXACT, TAIL_PAD, TAIL_PARTIAL, TAIL_NOISE} t_tail;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = 8'h00;  // char_in
    logic       i_s_axis_tlast  = 1'b0;   // message_end
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;           // byte_out
    logic       o_m_axis_tuser;           // byte_present
    logic       o_m_axis_tlast;           // run_last

    // decoder state as predicted
    logic [1:0]  grp_cnt  = '0;
    logic [17:0] sext_buf = '0;
    logic        halted   = 1'b0;
    b64d_pkg::t_result pending_results[$];

    int n_errors   = 0;
    int n_sent     = 0;
    int n_chars    = 0;
    int n_messages = 0;
    int n_bytes    = 0;
    int n_halts    = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit hold_off_req = 1'b0;

    base64_stream_decoder_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bit 6 set means the character is outside the alphabet
    function automatic logic [6:0] sextet_of_char(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
        if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 26);
        if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 52);
        if (ch == CHAR_PLUS) return 7'd62;
        if (ch == CHAR_SLASH) return 7'd63;
        return 7'd64;
    endfunction

    function automatic logic [7:0] random_b64_char();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic present,
                                        input logic last);
        b64d_pkg::t_result r;
        r.byte_out     = b;
        r.byte_present = present;
        r.run_last     = last;
        pending_results.push_back(r);
    endfunction

    // a partial group of k sextets yields k-1 bytes
    function automatic void flush_group();
        logic [23:0] w;
        if (grp_cnt >= 2'd2) begin
            w = {6'b0, sext_buf} << (6 * (4 - grp_cnt));
            push_result(w[23:16], 1'b1, 1'b0);
            if (grp_cnt == 2'd3) push_result(w[15:8], 1'b1, 1'b0);
        end
        grp_cnt  = '0;
        sext_buf = '0;
    endfunction

    function automatic void decode_char(input logic [7:0] ch, input logic eom);
        logic [6:0]  s;
        logic [23:0] w;
        int          start_cnt;
        start_cnt = pending_results.size();
        if (!halted) begin
            s = sextet_of_char(ch);
            if (!s[6]) begin
                if (grp_cnt == 2'd3) begin
                    w = {sext_buf, s[5:0]};
                    push_result(w[23:16], 1'b1, 1'b0);
                    push_result(w[15:8], 1'b1, 1'b0);
                    push_result(w[7:0], 1'b1, 1'b0);
                    grp_cnt  = '0;
                    sext_buf = '0;
                end else begin
                    sext_buf = {sext_buf[11:0], s[5:0]};
                    grp_cnt  = grp_cnt + 2'd1;
                end
            end else begin
                halted = 1'b1;
                n_halts++;
                flush_group();
            end
        end
        if (eom) begin
            if (!halted) flush_group();
            if (pending_results.size() == start_cnt) begin
                push_result(8'h00, 1'b0, 1'b1);
            end else begin
                pending_results[pending_results.size() - 1].run_last = 1'b1;
            end
            grp_cnt  = '0;
            sext_buf = '0;
            halted   = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %02h, actual %02h", name, want, got);
            n_errors++;
        end
    endfunction

    // input prediction first, then result checking, in one process per edge
    always @(posedge i_clk) begin : result_monitor
        b64d_pkg::t_result want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                n_chars++;
                if (i_s_axis_tlast) n_messages++;
                decode_char(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected transaction: byte_out=%02h byte_present=%0b run_last=%0b",
                           o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.byte_present) n_bytes++;
                    check_field("byte_out", want.byte_out, o_m_axis_tdata);
                    check_field("byte_present", 8'(want.byte_present), 8'(o_m_axis_tuser));
                    check_field("run_last", 8'(want.run_last), 8'(o_m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin : sink_pattern
        t_sink_mode mode;
        int         stretch;
        mode    = SINK_OPEN;
        stretch = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if (stretch == 0) begin
                mode    = t_sink_mode'($urandom_range(0, 2));
                stretch = $urandom_range(8, 40);
            end
            stretch--;
            case (mode)
                SINK_OPEN:     i_m_axis_tready <= 1'b1;
                SINK_RANDOM:   i_m_axis_tready <= ($urandom_range(0, 99) < 60);
                SINK_PERIODIC: i_m_axis_tready <= (stretch % 3 == 0);
                default:       i_m_axis_tready <= 1'b1;
            endcase
        end
    end

    // sender in bursts; valid stays high between items of one burst
    task automatic send_char(input logic [7:0] ch, input logic eom);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        n_sent++;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_bytes(input logic [7:0] msg[$]);
        for (int i = 0; i < msg.size(); i++) send_char(msg[i], i == msg.size() - 1);
    endtask

    task automatic test_whole_groups();
        send_text("TWFu////");
    endtask

    task automatic test_padding();
        send_text("TWE=");
        send_text("AA==");
    endtask

    task automatic test_lone_char();
        send_text("Q");
    endtask

    task automatic test_non_alphabet();
        // halt mid-group, then an ignored character that ends the message
        send_char("T", 1'b0);
        send_char("W", 1'b0);
        send_char(8'hff, 1'b0);
        send_char("A", 1'b1);
        send_char(8'h00, 1'b1);
        // halting character that also ends the message
        send_char(CHAR_PLUS, 1'b0);
        send_char(CHAR_SLASH, 1'b0);
        send_char("9", 1'b0);
        send_char(8'h80, 1'b1);
    endtask

    task automatic test_backpressure();
        burst_left   = 40;
        hold_off_req = 1'b1;
        for (int i = 0; i < 32; i++) send_char(random_b64_char(), i == 31);
    endtask

    task automatic test_random_messages();
        logic [7:0] msg[$];
        t_tail      tail;
        int         groups;
        int         k;
        int         pick;
        while (n_sent < RANDOM_ITEMS + 60) begin
            msg.delete();
            groups = $urandom_range(0, 3);
            pick   = $urandom_range(0, 7);
            tail   = (pick < 3) ? TAIL_EXACT : (pick < 5) ? TAIL_PAD :
                     (pick < 6) ? TAIL_PARTIAL : TAIL_NOISE;
            for (int i = 0; i < 4 * groups; i++) msg.push_back(random_b64_char());
            case (tail)
                TAIL_EXACT: begin
                    if (msg.size() == 0) msg.push_back(random_b64_char());
                end
                TAIL_PAD: begin
                    k = $urandom_range(2, 3);
                    for (int i = 0; i < k; i++) msg.push_back(random_b64_char());
                    for (int i = k; i < 4; i++) msg.push_back(CHAR_PAD);
                end
                TAIL_PARTIAL: begin
                    k = $urandom_range(1, 3);
                    for (int i = 0; i < k; i++) msg.push_back(random_b64_char());
                end
                default: begin
                    k = $urandom_range(0, 3);
                    for (int i = 0; i < k; i++) msg.push_back(random_b64_char());
                    case ($urandom_range(0, 2))
                        0:       msg.push_back(CHAR_PAD);
                        1:       msg.push_back(8'($urandom_range(128, 255)));
                        default: msg.push_back(8'($urandom_range(0, 255)));
                    endcase
                    k = $urandom_range(0, 3);
                    for (int i = 0; i < k; i++) msg.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            send_bytes(msg);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_whole_groups();
        test_padding();
        test_lone_char();
        test_non_alphabet();
        test_backpressure();
        test_random_messages();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected transactions never arrived", pending_results.size());
            n_errors++;
        end
        $display("decoded %0d characters in %0d messages, %0d bytes checked",
                 n_chars, n_messages, n_bytes);
        $display("%0d messages stopped early on padding or bad characters, one long output stall",
                 n_halts);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/b64d_pkg.sv
design/b64d_decode.sv
design/b64d_outq.sv
design/base64_stream_decoder_unit.sv
tb/testbench.sv
